/* rtl/sft_pkg.sv */
// Package for the spring follow tracker: widths, register indexes, state types
// and saturation helpers shared by the tracker top level and its scaling unit.
// No dependencies.
package sft_pkg;

    localparam int POS_W  = 32;
    localparam int GI_W   = 41;
    localparam int HW     = GI_W + 3;
    localparam int KW     = 16;
    localparam int VW     = 32;
    localparam int DT_W   = 16;
    localparam int LIM_W  = 31;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 3;
    localparam int CNT_W  = 5;

    localparam logic [KW-1:0]    RST_GAIN_K = 16'd2560;
    localparam logic [KW-1:0]    RST_GAIN_D = 16'd2560;
    localparam logic [LIM_W-1:0] RST_LIMIT  = 31'd1536000;
    localparam logic [3:0]       RST_FLAGS  = 4'd3;

    localparam int FLAG_FX     = 0;
    localparam int FLAG_FY     = 1;
    localparam int FLAG_SPRING = 2;
    localparam int FLAG_CLAMP  = 3;

    typedef enum logic [ADDR_W-1:0] {
        CFG_GAIN_K = 3'd0,
        CFG_GAIN_D = 3'd1,
        CFG_LIMIT  = 3'd2,
        CFG_FLAGS  = 3'd3,
        CFG_MIN_X  = 3'd4,
        CFG_MAX_X  = 3'd5,
        CFG_MIN_Y  = 3'd6,
        CFG_MAX_Y  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIFF, S_GAIN, S_VEL, S_SQR, S_CMP,
        S_SCALE, S_STEP, S_POS, S_CLAMP, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        P_IDLE, P_ROOT, P_MUL, P_DIV, P_DONE
    } t_scl_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scale_stat;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
        lo_lim = -hi_lim - 64'sd1;
        if (v > hi_lim) begin
            sat_pos = hi_lim[POS_W-1:0];
        end else if (v < lo_lim) begin
            sat_pos = lo_lim[POS_W-1:0];
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

    function automatic logic signed [GI_W-1:0] sat_gi(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (GI_W - 1)) - 64'sd1;
        lo_lim = -hi_lim - 64'sd1;
        if (v > hi_lim) begin
            sat_gi = hi_lim[GI_W-1:0];
        end else if (v < lo_lim) begin
            sat_gi = lo_lim[GI_W-1:0];
        end else begin
            sat_gi = v[GI_W-1:0];
        end
    endfunction

    function automatic logic signed [VW-1:0] sat_vel(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (VW - 1)) - 64'sd1;
        lo_lim = -hi_lim - 64'sd1;
        if (v > hi_lim) begin
            sat_vel = hi_lim[VW-1:0];
        end else if (v < lo_lim) begin
            sat_vel = lo_lim[VW-1:0];
        end else begin
            sat_vel = v[VW-1:0];
        end
    endfunction

endpackage

/* rtl/spring_follow_tracker_2d.sv */
// Spring follow tracker top level: stream ports, register file, update sequencer
// with bit-serial gain, square and time step units. Depends on sft_pkg, sft_scale.
// Sequence: with spring mode off a transfer runs S_PREP, S_CLAMP, S_DONE; with
//   spring mode on also S_DIFF, the gain, S_VEL, the squares, S_CMP, the time
//   step and S_POS; when the speed limit clips, S_SCALE waits on the square root,
//   product and division in sft_scale. Flow: one item at a time; the next transfer
//   is taken once a result is registered at the output. Reset (synchronous)
//   restores register defaults and zero tracked position and error.
module spring_follow_tracker_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // target_x, target_y, time_step
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // pos_x, pos_y
    output logic        o_m_tuser,   // speed_clipped
    input  logic        i_cfg_we,
    input  logic [sft_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [sft_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int PW = sft_pkg::POS_W;
    localparam int HW = sft_pkg::HW;

    sft_pkg::t_state r_state, n_state;
    logic [sft_pkg::KW-1:0]    r_gain_k, r_gain_d;
    logic [sft_pkg::LIM_W-1:0] r_lim;
    logic [3:0]                r_flags;
    logic [31:0]               r_bmin [2];
    logic [31:0]               r_bmax [2];

    logic signed [PW-1:0] r_trk [2];
    logic signed [PW-1:0] n_trk [2];
    logic signed [PW-1:0] r_lerr [2];
    logic signed [PW-1:0] n_lerr [2];
    logic signed [PW-1:0] r_tgt [2];
    logic signed [PW-1:0] n_tgt [2];
    logic signed [PW-1:0] r_err [2];
    logic signed [PW-1:0] n_err [2];
    logic signed [sft_pkg::GI_W-1:0] r_ge [2];
    logic signed [sft_pkg::GI_W-1:0] n_ge [2];
    logic signed [sft_pkg::GI_W-1:0] r_gd [2];
    logic signed [sft_pkg::GI_W-1:0] n_gd [2];
    logic signed [HW-1:0] r_gh [2];
    logic signed [HW-1:0] n_gh [2];
    logic [15:0] r_gl [2];
    logic [15:0] n_gl [2];
    logic signed [sft_pkg::VW-1:0] r_vel [2];
    logic signed [sft_pkg::VW-1:0] n_vel [2];
    logic [sft_pkg::VW-1:0] r_mag [2];
    logic [sft_pkg::VW-1:0] n_mag [2];
    logic [31:0] r_sa [2];
    logic [31:0] n_sa [2];
    logic signed [33:0] r_sth [2];
    logic signed [33:0] n_sth [2];
    logic [sft_pkg::KW-1:0] r_ks, n_ks, r_ds, n_ds;
    logic [33:0] r_sh, n_sh;
    logic [31:0] r_sl, n_sl, r_lh, n_lh, r_ll, n_ll, r_ls, n_ls;
    logic [sft_pkg::DT_W-1:0] r_dt, n_dt, r_dts, n_dts;
    logic [sft_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_clip, n_clip;
    logic r_out_valid, n_out_valid;
    logic [31:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic r_out_clip, n_out_clip;

    logic w_accept;
    logic w_start;
    logic signed [HW:0] w_gt [2];
    logic signed [HW:0] w_gs [2];
    logic signed [sft_pkg::VW-1:0] w_v [2];
    logic signed [sft_pkg::VW:0] w_v33 [2];
    logic signed [34:0] w_ps [2];
    logic signed [PW-1:0] w_e [2];
    logic signed [PW-1:0] w_p [2];
    logic signed [PW-1:0] w_lo [2];
    logic signed [PW-1:0] w_hi [2];
    logic signed [sft_pkg::VW:0] w_r33 [2];
    logic [34:0] w_ss;
    logic [32:0] w_ls;
    logic [sft_pkg::LIM_W-1:0] w_res [2];
    sft_pkg::t_scale_stat w_stat;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == sft_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_y, r_out_x};
    assign o_m_tuser  = r_out_clip;

    sft_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sum   ({r_sh[31:0], r_sl}),
        .i_mag   (r_mag),
        .i_lim   (r_lim),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sft_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_gain_k    <= sft_pkg::RST_GAIN_K;
            r_gain_d    <= sft_pkg::RST_GAIN_D;
            r_lim       <= sft_pkg::RST_LIMIT;
            r_flags     <= sft_pkg::RST_FLAGS;
            for (int l = 0; l < 2; l++) begin
                r_bmin[l] <= '0;
                r_bmax[l] <= '0;
                r_trk[l]  <= '0;
                r_lerr[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_trk       <= n_trk;
            r_lerr      <= n_lerr;
            if (i_cfg_we) begin
                case (sft_pkg::t_cfg_idx'(i_cfg_addr))
                    sft_pkg::CFG_GAIN_K: r_gain_k  <= i_cfg_wdata[sft_pkg::KW-1:0];
                    sft_pkg::CFG_GAIN_D: r_gain_d  <= i_cfg_wdata[sft_pkg::KW-1:0];
                    sft_pkg::CFG_LIMIT:  r_lim     <= i_cfg_wdata[sft_pkg::LIM_W-1:0];
                    sft_pkg::CFG_FLAGS:  r_flags   <= i_cfg_wdata[3:0];
                    sft_pkg::CFG_MIN_X:  r_bmin[0] <= i_cfg_wdata;
                    sft_pkg::CFG_MAX_X:  r_bmax[0] <= i_cfg_wdata;
                    sft_pkg::CFG_MIN_Y:  r_bmin[1] <= i_cfg_wdata;
                    sft_pkg::CFG_MAX_Y:  r_bmax[1] <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt      <= n_tgt;
        r_err      <= n_err;
        r_ge       <= n_ge;
        r_gd       <= n_gd;
        r_gh       <= n_gh;
        r_gl       <= n_gl;
        r_vel      <= n_vel;
        r_mag      <= n_mag;
        r_sa       <= n_sa;
        r_sth      <= n_sth;
        r_ks       <= n_ks;
        r_ds       <= n_ds;
        r_sh       <= n_sh;
        r_sl       <= n_sl;
        r_lh       <= n_lh;
        r_ll       <= n_ll;
        r_ls       <= n_ls;
        r_dt       <= n_dt;
        r_dts      <= n_dts;
        r_clip     <= n_clip;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_clip <= n_out_clip;
    end

    always_comb begin
        n_state     = r_state;
        n_trk       = r_trk;
        n_lerr      = r_lerr;
        n_tgt       = r_tgt;
        n_err       = r_err;
        n_ge        = r_ge;
        n_gd        = r_gd;
        n_gh        = r_gh;
        n_gl        = r_gl;
        n_vel       = r_vel;
        n_mag       = r_mag;
        n_sa        = r_sa;
        n_sth       = r_sth;
        n_ks        = r_ks;
        n_ds        = r_ds;
        n_sh        = r_sh;
        n_sl        = r_sl;
        n_lh        = r_lh;
        n_ll        = r_ll;
        n_ls        = r_ls;
        n_dt        = r_dt;
        n_dts       = r_dts;
        n_cnt       = r_cnt;
        n_clip      = r_clip;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_clip  = r_out_clip;
        w_start     = 1'b0;

        for (int l = 0; l < 2; l++) begin
            w_gt[l]  = (r_ks[0] ? (HW+1)'(r_ge[l]) : '0) - (r_ds[0] ? (HW+1)'(r_gd[l]) : '0);
            w_gs[l]  = (HW+1)'(r_gh[l]) + w_gt[l];
            w_v[l]   = r_flags[l] ? sft_pkg::sat_vel(64'(signed'({r_gh[l], r_gl[l][15:8]})))
                                  : '0;
            w_v33[l] = (sft_pkg::VW+1)'(w_v[l]);
            w_ps[l]  = 35'(r_sth[l]) + (r_dts[0] ? 35'(r_vel[l]) : 35'sd0);
            w_e[l]   = sft_pkg::sat_pos(64'(r_tgt[l]) - 64'(r_trk[l]));
            w_lo[l]  = sft_pkg::sat_pos(64'(signed'(r_bmin[l])));
            w_hi[l]  = sft_pkg::sat_pos(64'(signed'(r_bmax[l])));
            w_p[l]   = r_trk[l];
            if (w_p[l] < w_lo[l]) begin
                w_p[l] = w_lo[l];
            end
            if (w_p[l] > w_hi[l]) begin
                w_p[l] = w_hi[l];
            end
            w_r33[l] = (sft_pkg::VW+1)'({1'b0, w_res[l]});
        end
        w_ss = {1'b0, r_sh} + (r_sa[0][0] ? {3'b000, r_mag[0]} : 35'd0)
             + (r_sa[1][0] ? {3'b000, r_mag[1]} : 35'd0);
        w_ls = {1'b0, r_lh} + (r_ls[0] ? {2'b00, r_lim} : 33'd0);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            sft_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_tgt[0] = sft_pkg::sat_pos(64'(signed'(i_s_tdata[31:0])));
                    n_tgt[1] = sft_pkg::sat_pos(64'(signed'(i_s_tdata[63:32])));
                    n_dt     = i_s_tdata[79:64];
                    n_clip   = 1'b0;
                    n_state  = sft_pkg::S_PREP;
                end
            end
            sft_pkg::S_PREP: begin
                if (r_flags[sft_pkg::FLAG_SPRING]) begin
                    n_err   = w_e;
                    n_state = sft_pkg::S_DIFF;
                end else begin
                    for (int l = 0; l < 2; l++) begin
                        if (r_flags[l]) begin
                            n_trk[l] = r_tgt[l];
                        end
                    end
                    n_state = sft_pkg::S_CLAMP;
                end
            end
            sft_pkg::S_DIFF: begin
                for (int l = 0; l < 2; l++) begin
                    n_ge[l] = sft_pkg::sat_gi(64'(r_err[l]));
                    n_gd[l] = sft_pkg::sat_gi(64'(r_err[l]) - 64'(r_lerr[l]));
                    n_gh[l] = '0;
                end
                n_ks    = r_gain_k;
                n_ds    = r_gain_d;
                n_cnt   = '0;
                n_state = sft_pkg::S_GAIN;
            end
            sft_pkg::S_GAIN: begin
                for (int l = 0; l < 2; l++) begin
                    n_gh[l] = w_gs[l][HW:1];
                    n_gl[l] = {w_gs[l][0], r_gl[l][15:1]};
                end
                n_ks  = r_ks >> 1;
                n_ds  = r_ds >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == 4'd15) begin
                    n_state = sft_pkg::S_VEL;
                end
            end
            sft_pkg::S_VEL: begin
                for (int l = 0; l < 2; l++) begin
                    n_vel[l] = w_v[l];
                    n_mag[l] = w_v[l][sft_pkg::VW-1] ? 32'(-w_v33[l]) : 32'(w_v33[l]);
                    n_sa[l]  = n_mag[l];
                end
                n_ls    = {1'b0, r_lim};
                n_sh    = '0;
                n_lh    = '0;
                n_cnt   = '0;
                n_state = sft_pkg::S_SQR;
            end
            sft_pkg::S_SQR: begin
                n_sh = w_ss[34:1];
                n_sl = {w_ss[0], r_sl[31:1]};
                n_lh = w_ls[32:1];
                n_ll = {w_ls[0], r_ll[31:1]};
                for (int l = 0; l < 2; l++) begin
                    n_sa[l] = r_sa[l] >> 1;
                end
                n_ls  = r_ls >> 1;
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = sft_pkg::S_CMP;
                end
            end
            sft_pkg::S_CMP: begin
                n_sth[0] = '0;
                n_sth[1] = '0;
                n_dts    = r_dt;
                n_cnt    = '0;
                if ({r_sh[31:0], r_sl} > {r_lh, r_ll}) begin
                    n_clip  = 1'b1;
                    w_start = 1'b1;
                    n_state = sft_pkg::S_SCALE;
                end else begin
                    n_state = sft_pkg::S_STEP;
                end
            end
            sft_pkg::S_SCALE: begin
                if (w_stat.done) begin
                    for (int l = 0; l < 2; l++) begin
                        n_vel[l] = r_vel[l][sft_pkg::VW-1] ? sft_pkg::VW'(-w_r33[l])
                                                            : sft_pkg::VW'(w_r33[l]);
                    end
                    n_state = sft_pkg::S_STEP;
                end
            end
            sft_pkg::S_STEP: begin
                for (int l = 0; l < 2; l++) begin
                    n_sth[l] = w_ps[l][34:1];
                end
                n_dts = r_dts >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == 4'd15) begin
                    n_state = sft_pkg::S_POS;
                end
            end
            sft_pkg::S_POS: begin
                for (int l = 0; l < 2; l++) begin
                    n_trk[l]  = sft_pkg::sat_pos(64'(r_trk[l]) + 64'(r_sth[l]));
                    n_lerr[l] = r_err[l];
                end
                n_state = sft_pkg::S_CLAMP;
            end
            sft_pkg::S_CLAMP: begin
                if (r_flags[sft_pkg::FLAG_CLAMP]) begin
                    n_trk = w_p;
                end
                n_state = sft_pkg::S_DONE;
            end
            sft_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = 32'(r_trk[0]);
                    n_out_y     = 32'(r_trk[1]);
                    n_out_clip  = r_clip;
                    n_state     = sft_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sft_pkg::S_IDLE;
            end
        endcase
    end

    ap_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == sft_pkg::S_PREP)
        else $error("transfer did not start an update");

    ap_done_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_state == sft_pkg::S_SCALE)
        else $error("scale unit finished outside the wait state");

    ap_scale_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sft_pkg::S_SCALE && !w_stat.done) |-> w_stat.busy)
        else $error("waiting on an idle scale unit");

    ap_clip_spring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> r_flags[sft_pkg::FLAG_SPRING])
        else $error("clip flagged without spring mode");

    ap_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sft_pkg::S_DONE && (!r_out_valid || i_m_tready)) |=> r_out_valid)
        else $error("finished update not presented");

endmodule

/* rtl/sft_scale.sv */
// Speed limit scaling unit: bit-serial square root of the squared speed, then
// per axis a shift-add product with the limit and a restoring division.
// Depends on sft_pkg.
module sft_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [63:0]                      i_sum,
    input  logic [sft_pkg::VW-1:0]           i_mag [2],
    input  logic [sft_pkg::LIM_W-1:0]        i_lim,
    output sft_pkg::t_scale_stat             o_stat,
    output logic [sft_pkg::LIM_W-1:0]        o_res [2]
);

    sft_pkg::t_scl_state r_state, n_state;
    logic [sft_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0] r_rad, n_rad;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [31:0] r_ls, n_ls;
    logic [31:0] r_mag [2];
    logic [31:0] n_mag [2];
    logic [31:0] r_hi [2];
    logic [31:0] n_hi [2];
    logic [31:0] r_lo [2];
    logic [31:0] n_lo [2];

    logic [35:0] w_rt;
    logic [35:0] w_tr;
    logic [32:0] w_ms [2];
    logic [32:0] w_dt [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sft_pkg::P_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_ls   <= n_ls;
        for (int l = 0; l < 2; l++) begin
            r_mag[l] <= n_mag[l];
            r_hi[l]  <= n_hi[l];
            r_lo[l]  <= n_lo[l];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_ls    = r_ls;
        for (int l = 0; l < 2; l++) begin
            n_mag[l] = r_mag[l];
            n_hi[l]  = r_hi[l];
            n_lo[l]  = r_lo[l];
            w_ms[l]  = {1'b0, r_hi[l]} + (r_ls[0] ? {1'b0, r_mag[l]} : 33'd0);
            w_dt[l]  = {r_hi[l], r_lo[l][31]};
        end
        w_rt = {r_rem, r_rad[63:62]};
        w_tr = {2'b00, r_root, 2'b01};
        o_stat.busy = (r_state != sft_pkg::P_IDLE);
        o_stat.done = 1'b0;
        case (r_state)
            sft_pkg::P_IDLE: begin
                if (i_start) begin
                    n_rad   = i_sum;
                    n_rem   = '0;
                    n_root  = '0;
                    n_ls    = {1'b0, i_lim};
                    n_mag   = i_mag;
                    n_cnt   = '0;
                    n_state = sft_pkg::P_ROOT;
                end
            end
            sft_pkg::P_ROOT: begin
                n_rad = {r_rad[61:0], 2'b00};
                if (w_rt >= w_tr) begin
                    n_rem  = 34'(w_rt - w_tr);
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem  = w_rt[33:0];
                    n_root = {r_root[30:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    for (int l = 0; l < 2; l++) begin
                        n_hi[l] = '0;
                        n_lo[l] = '0;
                    end
                    n_state = sft_pkg::P_MUL;
                end
            end
            sft_pkg::P_MUL: begin
                for (int l = 0; l < 2; l++) begin
                    n_hi[l] = w_ms[l][32:1];
                    n_lo[l] = {w_ms[l][0], r_lo[l][31:1]};
                end
                n_ls  = r_ls >> 1;
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = sft_pkg::P_DIV;
                end
            end
            sft_pkg::P_DIV: begin
                for (int l = 0; l < 2; l++) begin
                    if (w_dt[l] >= {1'b0, r_root}) begin
                        n_hi[l] = 32'(w_dt[l] - {1'b0, r_root});
                        n_lo[l] = {r_lo[l][30:0], 1'b1};
                    end else begin
                        n_hi[l] = w_dt[l][31:0];
                        n_lo[l] = {r_lo[l][30:0], 1'b0};
                    end
                end
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = sft_pkg::P_DONE;
                end
            end
            sft_pkg::P_DONE: begin
                o_stat.done = 1'b1;
                n_state     = sft_pkg::P_IDLE;
            end
            default: begin
                n_state = sft_pkg::P_IDLE;
            end
        endcase
    end

    assign o_res[0] = r_lo[0][sft_pkg::LIM_W-1:0];
    assign o_res[1] = r_lo[1][sft_pkg::LIM_W-1:0];

endmodule
